[rtl/core/mmam_pkg.sv]
// ----------------------------------------------------------------------------
// mmam_pkg
// Shared types and constants for the mix-minus audio mixer: request and
// result payloads, command codes, register indexes and controller types.
// ----------------------------------------------------------------------------
package mmam_pkg;

    // Default number of stereo frame pairs held in the sum store
    localparam int FRAME_PAIRS_DEF = 1024;
    // Streams that may take part in the mix
    localparam int MAX_STREAMS     = 9;
    // Width of the per-stream configuration masks
    localparam int MASK_W          = 9;

    // Sum store: two saturating channel sums per entry
    localparam int ACC_W   = 20;
    localparam int ENTRY_W = 2 * ACC_W;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int STREAM_W = 4;
    localparam int POS_W    = 11;
    localparam int SAMPLE_W = 16;

    // Output clip limits
    localparam logic signed [SAMPLE_W-1:0] OUT_MAX = 16'sd32767;
    localparam logic signed [SAMPLE_W-1:0] OUT_MIN = -16'sd32768;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_MASK  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO_MASK = 1'd1;

    // Request commands
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 2'd0,
        CMD_ADD     = 2'd1,
        CMD_READ    = 2'd2,
        CMD_READ_MM = 2'd3
    } t_cmd;

    // Request payload
    typedef struct packed {
        t_cmd                        cmd;
        logic [STREAM_W-1:0]         stream;
        logic [POS_W-1:0]            position;
        logic signed [SAMPLE_W-1:0]  sample;
        logic                        last;
    } t_in_item;

    // Result payload
    typedef struct packed {
        logic signed [SAMPLE_W-1:0]  mixed;
        logic [POS_W-1:0]            out_position;
        logic                        frame_end;
    } t_out_item;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_FETCH = 2'd1,
        ST_EXEC  = 2'd2
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic latch;     // capture the accepted request
        logic fetch;     // read the sum store entry
        logic write;     // write back a load or add
        logic load_out;  // load the result register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_read;   // held request produces a result
        logic out_busy;  // result register full and not taken this cycle
    } t_dp_stat;

endpackage

[rtl/core/mmam_ctrl.sv]
// ----------------------------------------------------------------------------
// mmam_ctrl
// Sequencer for the mixer: accepts a request, fetches its sum store entry,
// then writes it back or hands the result to the output register.
// ----------------------------------------------------------------------------
module mmam_ctrl
    import mmam_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // Hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Advance through accept, fetch and execute
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_FETCH;
                end
            end
            ST_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = ST_EXEC;
            end
            ST_EXEC: begin
                if (!i_stat.is_read) begin
                    o_cmd.write = 1'b1;
                    n_state     = ST_IDLE;
                end else if (!i_stat.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/mmam_dpath.sv]
// ----------------------------------------------------------------------------
// mmam_dpath
// Datapath for the mixer: configuration masks, request register, sum store
// with read-modify-write saturating update, clip and result register.
// ----------------------------------------------------------------------------
module mmam_dpath
    import mmam_pkg::*;
#(
    parameter int FRAME_PAIRS = FRAME_PAIRS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [MASK_W-1:0]    i_cfg_data,
    input  t_in_item             i_in_data,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data
);

    localparam int AW = (FRAME_PAIRS > 1) ? $clog2(FRAME_PAIRS) : 1;

    logic [MASK_W-1:0]  r_valid_mask;
    logic [MASK_W-1:0]  r_stereo_mask;
    t_in_item           r_item;
    logic [ENTRY_W-1:0] r_rdata;
    logic [ENTRY_W-1:0] mem [FRAME_PAIRS];
    t_out_item          r_out;
    logic               r_out_valid;

    logic                     w_is_read;
    logic                     w_stream_ok;
    logic                     w_stereo;
    logic                     w_halve;
    logic [POS_W-1:0]         w_frame;
    logic [31:0]              w_frame_ext;
    logic                     w_in_range;
    logic [AW-1:0]            w_addr;
    logic                     w_load;
    logic signed [ACC_W-1:0]  w_left;
    logic signed [ACC_W-1:0]  w_right;
    logic signed [ACC_W-1:0]  w_new_left;
    logic signed [ACC_W-1:0]  w_new_right;
    logic signed [ACC_W-1:0]  w_sel;
    logic signed [ACC_W:0]    w_diff;
    logic signed [SAMPLE_W-1:0] w_mixed;
    logic                     w_wr_en;
    logic [ENTRY_W-1:0]       w_wdata;

    // Saturate a widened sum to the channel sum range
    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
        logic signed [ACC_W:0] hi;
        logic signed [ACC_W:0] lo;
        hi = (ACC_W+1)'((1 <<< (ACC_W-1)) - 1);
        lo = -(ACC_W+1)'(1 <<< (ACC_W-1));
        if (v > hi) begin
            sat_acc = hi[ACC_W-1:0];
        end else if (v < lo) begin
            sat_acc = lo[ACC_W-1:0];
        end else begin
            sat_acc = v[ACC_W-1:0];
        end
    endfunction

    // Add a sample to a channel sum, or load it over the sum
    function automatic logic signed [ACC_W-1:0] update(
        input logic signed [ACC_W-1:0]    base,
        input logic signed [SAMPLE_W-1:0] s,
        input logic                       load
    );
        logic signed [ACC_W:0] b;
        b = load ? '0 : (ACC_W+1)'(base);
        update = sat_acc(b + (ACC_W+1)'(s));
    endfunction

    // Write configuration masks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_mask  <= '0;
            r_stereo_mask <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_VALID_MASK:  r_valid_mask  <= i_cfg_data;
                CFG_STEREO_MASK: r_stereo_mask <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Capture the accepted request
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_in_data;
        end
    end

    // Decode frame index, channel and stream eligibility
    always_comb begin
        w_is_read   = (r_item.cmd == CMD_READ) || (r_item.cmd == CMD_READ_MM);
        w_stream_ok = (32'(r_item.stream) < 32'(MAX_STREAMS))
                      && ((r_valid_mask >> r_item.stream) & MASK_W'(1)) != '0;
        w_stereo    = ((r_stereo_mask >> r_item.stream) & MASK_W'(1)) != '0;
        w_halve     = w_is_read || w_stereo;
        w_frame     = w_halve ? (r_item.position >> 1) : r_item.position;
        w_frame_ext = 32'(w_frame);
        w_in_range  = w_frame_ext < 32'(FRAME_PAIRS);
        w_addr      = w_frame_ext[AW-1:0];
        w_load      = (r_item.cmd == CMD_LOAD);
    end

    // Build the write-back entry
    always_comb begin
        w_left      = r_rdata[ACC_W-1:0];
        w_right     = r_rdata[ENTRY_W-1:ACC_W];
        w_new_left  = w_left;
        w_new_right = w_right;
        if (!w_stereo || !r_item.position[0]) begin
            w_new_left = update(w_left, r_item.sample, w_load);
        end
        if (!w_stereo || r_item.position[0]) begin
            w_new_right = update(w_right, r_item.sample, w_load);
        end
        w_wdata = {w_new_right, w_new_left};
        w_wr_en = i_cmd.write && w_stream_ok && w_in_range;
    end

    // Form the clipped read result
    always_comb begin
        w_sel  = r_item.position[0] ? w_right : w_left;
        w_diff = (ACC_W+1)'(w_sel);
        if (r_item.cmd == CMD_READ_MM) begin
            w_diff = w_diff - (ACC_W+1)'(r_item.sample);
        end
        if (!w_in_range) begin
            w_mixed = '0;
        end else if (w_diff > (ACC_W+1)'(OUT_MAX)) begin
            w_mixed = OUT_MAX;
        end else if (w_diff < (ACC_W+1)'(OUT_MIN)) begin
            w_mixed = OUT_MIN;
        end else begin
            w_mixed = w_diff[SAMPLE_W-1:0];
        end
    end

    // Sum store: one read or one write a cycle
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_addr] <= w_wdata;
        end
        if (i_cmd.fetch) begin
            r_rdata <= mem[w_addr];
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.mixed        <= w_mixed;
            r_out.out_position <= r_item.position;
            r_out.frame_end    <= r_item.last;
        end
    end

    // Result register valid: set on load, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.is_read  = w_is_read;
    assign o_stat.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

endmodule

[rtl/core/mix_minus_audio_mixer_top.sv]
// ----------------------------------------------------------------------------
// mix_minus_audio_mixer_top
// Mix-minus conference mixer: stereo sum store with load, add and clipped
// full-mix or mix-minus reads.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on i_in_valid / o_in_ready with payload i_in_data. Load
//   and add requests update the sum store and give no result; full-mix and
//   mix-minus reads give one result on o_out_valid / i_out_ready.
//   Configuration masks are written through i_cfg_we, i_cfg_index and
//   i_cfg_data while the block is idle; writes take effect at once.
// Timing:
//   Each request steps through accept, sum store read, then write-back or
//   result load. The single-port sum store read-modify-write sets this, so
//   a new request is taken only once the last one is done. A read result
//   shows on o_out_valid once the result register is loaded.
// Reset and stall:
//   Reset clears the masks, the sequencer and the result valid; the sum
//   store holds no defined value until loaded. A stalled receiver does not
//   block loads and adds; a read waits in its last step until the result
//   register frees up.
// ----------------------------------------------------------------------------
module mix_minus_audio_mixer_top
    import mmam_pkg::*;
#(
    parameter int FRAME_PAIRS = FRAME_PAIRS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [MASK_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequencer
    mmam_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Sum store and arithmetic
    mmam_dpath #(
        .FRAME_PAIRS (FRAME_PAIRS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
